@@ src/swm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window minimum
// Holds the widths, the controller state type and the command/status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int MAX_WINDOW   = 16;
    localparam int SAMPLE_WIDTH = 32;
    localparam int SLOT_W       = $clog2(MAX_WINDOW);
    localparam int FILL_W       = $clog2(MAX_WINDOW + 1);
    localparam int CFG_W        = 5;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } swm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // capture a new sample and update the store
        logic scan;      // compare one stored sample against the running minimum
        logic load_out;  // move the finished minimum into the output register
    } swm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic produce;   // the sample being accepted completes a full window
        logic win_one;   // the effective window is a single sample
        logic scan_done; // the current scan step is the final one
        logic out_free;  // the output register can take a new result
    } swm_stat_t;

endpackage

@@ src/swm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ctrl: sequencing state machine
// Accepts one sample at a time, steps the datapath through the window scan
// and hands the finished minimum to the output register.
// ----------------------------------------------------------------------------
module swm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  swm_pkg::swm_stat_t stat,
    output swm_pkg::swm_cmd_t  cmd
);
    import swm_pkg::*;

    swm_state_t state_reg;
    swm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.scan     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (stat.produce) begin
                        state_next = stat.win_one ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/swm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_dp: window store, counters and minimum datapath
// Keeps the circular sample store, the fill count and write slot, the
// window length register, the running minimum and the output register.
// ----------------------------------------------------------------------------
module swm_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [swm_pkg::CFG_W-1:0]     cfg_data,
    input  logic [swm_pkg::SAMPLE_WIDTH-1:0] in_sample,
    input  logic                          in_last,
    input  swm_pkg::swm_cmd_t             cmd,
    output swm_pkg::swm_stat_t            stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [swm_pkg::SAMPLE_WIDTH-1:0] out_min,
    output logic                          out_last
);
    import swm_pkg::*;

    logic [CFG_W-1:0]  win_len_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_inc;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic [SLOT_W-1:0] rd_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] last_idx_reg;
    logic [FILL_W-1:0] win_eff;
    logic              out_valid_reg;

    sample_t window_store_reg [MAX_WINDOW];
    sample_t best_reg;
    sample_t rd_data;
    sample_t out_min_reg;
    logic    last_reg;
    logic    out_last_reg;

    // A zero length acts as one, anything above the store depth saturates.
    always_comb begin
        if (win_len_reg == '0) begin
            win_eff = FILL_W'(1);
        end else if (FILL_W'(win_len_reg) > FILL_W'(MAX_WINDOW)) begin
            win_eff = FILL_W'(MAX_WINDOW);
        end else begin
            win_eff = FILL_W'(win_len_reg);
        end
    end

    assign fill_inc  = (fill_reg < FILL_W'(MAX_WINDOW)) ? fill_reg + FILL_W'(1) : fill_reg;
    assign fill_next = in_last ? '0 : fill_inc;
    assign slot_next = in_last ? '0 : slot_reg + SLOT_W'(1);
    assign rd_data   = window_store_reg[rd_reg];

    assign stat.produce   = (fill_inc >= win_eff);
    assign stat.win_one   = (win_eff == FILL_W'(1));
    assign stat.scan_done = (idx_reg == last_idx_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg   <= CFG_W'(1);
            fill_reg      <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                win_len_reg <= cfg_data;
            end
            if (cmd.accept) begin
                fill_reg <= fill_next;
                slot_reg <= slot_next;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            window_store_reg[slot_reg] <= sample_t'(in_sample);
            best_reg     <= sample_t'(in_sample);
            last_reg     <= in_last;
            rd_reg       <= slot_reg - SLOT_W'(1);
            idx_reg      <= SLOT_W'(1);
            last_idx_reg <= SLOT_W'(win_eff - FILL_W'(1));
        end else if (cmd.scan) begin
            if (rd_data < best_reg) begin
                best_reg <= rd_data;
            end
            rd_reg  <= rd_reg - SLOT_W'(1);
            idx_reg <= idx_reg + SLOT_W'(1);
        end
        if (cmd.load_out) begin
            out_min_reg  <= best_reg;
            out_last_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_min   = out_min_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(MAX_WINDOW))
        else $error("fill count exceeds the store depth");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && in_last) |=> (fill_reg == '0 && slot_reg == '0))
        else $error("final sample did not clear fill count and write slot");

    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> (idx_reg != '0 && idx_reg <= last_idx_reg))
        else $error("scan step outside the window");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |-> !cmd.load_out)
        else $error("pending result overwritten");
`endif

endmodule

@@ src/sliding_window_minimum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_minimum: running minimum over the latest samples of an array
// Streams signed samples in, grouped into arrays closed by tlast, and streams
// out the minimum of the latest window_len samples of the current array.
// ----------------------------------------------------------------------------
// Usage notes:
// The slave channel carries one signed sample per transaction, with s_tlast
// marking the final sample of an array. From the window_len-th sample of an
// array on, every sample produces one master transaction
// holding the minimum of the latest window_len samples; m_tlast is set on the
// result that belongs to the array's final sample. Shorter arrays yield no
// results. The window length is to be written through the cfg channel while
// the block is idle; the block itself does not enforce this. Zero acts as one
// and values above 16 act as 16. A sample that produces a result is accepted,
// then the single comparator walks the older stored samples of the window one
// per cycle, and then the minimum moves into the output register once that
// register is free. A sample that produces no result is only accepted. The
// result register lets the next sample be accepted while a result waits; if
// the receiver stalls longer, the block holds the next finished minimum and
// stops accepting until the output register frees.
// Reset sets the window length to one and empties the window; stored samples
// are not cleared, since only samples of the current array are ever read.
// ----------------------------------------------------------------------------
module sliding_window_minimum (
    input  logic        aclk,
    input  logic        aresetn,
    // Slave stream: tdata = sample[31:0].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    // Master stream: tdata = window_min[31:0].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    // Configuration: window_len[4:0].
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import swm_pkg::*;

    swm_cmd_t  cmd;
    swm_stat_t stat;

    // The window length register can always take a write.
    assign cfg_ready = 1'b1;

    // Controller: sequences accept, scan and hand-off to the output register.
    swm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: sample store, counters, comparator and output register.
    swm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_sample (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_min   (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

@@ verif/sliding_window_minimum_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_minimum_test: self-checking bench for the window minimum
// Streams arrays of signed samples into the block under random sender bursts
// and receiver stalls. A behavioral copy of the window store predicts every
// minimum and its last flag. Results are compared in order against that
// prediction. The window length is changed between arrays and within one.
// ----------------------------------------------------------------------------
module sliding_window_minimum_test;

    import swm_pkg::*;

    localparam int      CLK_HALF       = 4;
    localparam int      RESET_CYCLES   = 12;
    // Quiet margin before a window length write. The block is already idle
    // once every expected result has been taken.
    localparam int      SETTLE_CYCLES  = MAX_WINDOW + 8;
    localparam int      WATCHDOG_LIMIT = 2000;
    localparam int      RANDOM_ITEMS   = 1150;
    localparam int      MAX_REPORTS    = 50;
    localparam sample_t SAMPLE_MIN     = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam sample_t SAMPLE_MAX     = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_LONG_STALLS
    } rx_mode_t;

    typedef struct {
        sample_t window_min;
        logic    last_window;
    } window_result_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;
    logic              s_tlast   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [31:0]       m_tdata;
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data  = '0;

    // Predictor state: a private copy of the window store.
    logic [CFG_W-1:0]  window_setting = 5'd1;
    sample_t           window_hist [MAX_WINDOW];
    int                hist_fill = 0;
    int                hist_slot = 0;
    window_result_t    expected_minima [$];
    window_result_t    oldest_minimum;

    int                mismatches      = 0;
    int                samples_taken   = 0;
    int                minima_checked  = 0;
    int                arrays_sent     = 0;
    int                window_writes   = 0;
    int                burst_left      = 0;
    int                quiet_cycles    = 0;
    int                rx_mode_left    = 0;
    int                rx_stall_left   = 0;
    rx_mode_t          rx_mode         = RX_ALWAYS;
    logic [1:0]        rx_phase        = '0;

    sliding_window_minimum i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // sample[31:0]
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // window_min[31:0]
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)   // window_len[4:0]
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        // Keep the log readable when the block is badly broken.
        if (mismatches < MAX_REPORTS) begin
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        end
        mismatches++;
    endtask

    function automatic int effective_window(input logic [CFG_W-1:0] setting);
        if (setting == 0) begin
            return 1;
        end
        if (setting > MAX_WINDOW) begin
            return MAX_WINDOW;
        end
        return int'(setting);
    endfunction

    // Store one accepted sample and queue the minimum it completes, if any.
    task automatic track_sample(input sample_t value, input logic last);
        int             k;
        int             pos;
        sample_t        lowest;
        window_result_t entry;
        k = effective_window(window_setting);
        window_hist[hist_slot] = value;
        hist_slot = (hist_slot + 1) % MAX_WINDOW;
        if (hist_fill < MAX_WINDOW) begin
            hist_fill++;
        end
        if (hist_fill >= k) begin
            lowest = value;
            for (int i = 1; i < k; i++) begin
                pos = (hist_slot + MAX_WINDOW - 1 - i) % MAX_WINDOW;
                if (window_hist[pos] < lowest) begin
                    lowest = window_hist[pos];
                end
            end
            entry.window_min  = lowest;
            entry.last_window = last;
            expected_minima.insert(expected_minima.size(), entry);
        end
        if (last) begin
            hist_fill = 0;
            hist_slot = 0;
        end
    endtask

    // Every transaction on any channel is observed here, after the edge has
    // been sampled and before any of its updates land.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                window_setting = cfg_data;
                window_writes++;
            end
            if (s_tvalid && s_tready) begin
                samples_taken++;
                track_sample(sample_t'(s_tdata), s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (expected_minima.size() == 0) begin
                    report_mismatch("result with nothing expected", m_tdata, '0);
                end else begin
                    oldest_minimum = expected_minima.pop_front();
                    minima_checked++;
                    if (m_tdata !== oldest_minimum.window_min) begin
                        report_mismatch("window_min", m_tdata, oldest_minimum.window_min);
                    end
                    if (m_tlast !== oldest_minimum.last_window) begin
                        report_mismatch("last_window", {31'b0, m_tlast},
                                        {31'b0, oldest_minimum.last_window});
                    end
                end
            end
        end
    end

    // The run ends if no transaction of any kind happens for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("sliding_window_minimum_test NOT OK");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Receiver: picks a random stall pattern and holds it for a random span before switching.
    always @(posedge aclk) begin
        logic ready_next;
        ready_next = 1'b1;
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(50, 300);
        end else begin
            rx_mode_left--;
        end
        rx_phase++;
        case (rx_mode)
            RX_ALWAYS: begin
                ready_next = 1'b1;
            end
            RX_COIN: begin
                ready_next = $urandom_range(0, 1);
            end
            RX_ONE_IN_FOUR: begin
                ready_next = (rx_phase == 2'd0);
            end
            default: begin
                if (rx_stall_left > 0) begin
                    rx_stall_left--;
                    ready_next = 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    rx_stall_left = $urandom_range(5, 20);
                end
            end
        endcase
        m_tready <= aresetn && ready_next;
    end

    // Sends one sample; valid stays high across a burst and drops for a
    // random gap between bursts.
    task automatic send_sample(input sample_t value, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (last) begin
            arrays_sent++;
        end
    endtask

    // Holds the sender until every expected minimum has arrived, then idles
    // for a short margin.
    task automatic wait_for_minima();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_minima.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window_len(input logic [CFG_W-1:0] len);
        wait_for_minima();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic sample_t random_sample();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return SAMPLE_MIN;
                    1:       return SAMPLE_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            // Small values make ties within a window common.
            1, 2, 3: return sample_t'(int'($urandom_range(0, 16)) - 8);
            default: return sample_t'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_window_len();
        case ($urandom_range(0, 9))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return ($urandom_range(0, 1) == 0) ? 5'd31 : 5'($urandom_range(17, 30));
            default: return 5'($urandom_range(2, 15));
        endcase
    endfunction

    // The reset window of one passes every sample through, extremes included.
    task automatic test_reset_window();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample('1, 1'b1);
    endtask

    // A window length of zero acts as one.
    task automatic test_zero_window();
        write_window_len(5'd0);
        send_sample('0, 1'b1);
    endtask

    // An array shorter than the window yields nothing but still ends the array.
    task automatic test_short_array();
        write_window_len(5'd2);
        send_sample(sample_t'(-5), 1'b1);
    endtask

    // The window shrinks while an array is half delivered; the new length
    // takes effect on the samples already stored.
    task automatic test_mid_array_change();
        write_window_len(5'd3);
        send_sample(sample_t'(7), 1'b0);
        send_sample(sample_t'(-3), 1'b0);
        write_window_len(5'd2);
        send_sample(sample_t'(4), 1'b0);
        send_sample(sample_t'(9), 1'b1);
    endtask

    // Oversized setting saturates at the full store; the minimum sits in the
    // oldest entry of the window.
    task automatic test_saturated_window();
        write_window_len(5'd31);
        send_sample(SAMPLE_MIN, 1'b0);
        for (int i = 1; i < MAX_WINDOW - 1; i++) begin
            send_sample(random_sample(), 1'b0);
        end
        send_sample(SAMPLE_MAX, 1'b1);
    endtask

    // Phases of random arrays, each under its own window length; most arrays
    // are long enough to produce minima and many wrap the store.
    task automatic test_random_arrays();
        int k;
        int len;
        int split;
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            write_window_len(random_window_len());
            for (int a = $urandom_range(2, 8); a > 0 && sent < RANDOM_ITEMS; a--) begin
                k = effective_window(window_setting);
                if (k > 1 && $urandom_range(0, 9) == 0) begin
                    len = $urandom_range(1, k - 1);
                end else begin
                    len = $urandom_range(k, k + 24);
                end
                split = ($urandom_range(0, 11) == 0) ? $urandom_range(1, len) : 0;
                if ($urandom_range(0, 19) == 0) begin
                    wait_for_minima();
                end
                for (int i = 1; i <= len; i++) begin
                    if (i == split) begin
                        write_window_len(random_window_len());
                    end
                    send_sample(random_sample(), i == len);
                end
                sent += len;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_window();
        test_zero_window();
        test_short_array();
        test_mid_array_change();
        test_saturated_window();
        test_random_arrays();
        wait_for_minima();
        $display("Sent %0d samples in %0d arrays under %0d window settings,",
                 samples_taken, arrays_sent, window_writes);
        $display("checked %0d window minima with %0d mismatches.", minima_checked, mismatches);
        if (mismatches == 0) begin
            $display("sliding_window_minimum_test OK");
        end else begin
            $display("sliding_window_minimum_test NOT OK");
        end
        $finish;
    end

endmodule
